[rtl/core/three_stacks_shared_memory_macros.svh]
// ----------------------------------------------------------------------------
// three_stacks_shared_memory_macros
// assertion macros for the shared-memory stack block
// ----------------------------------------------------------------------------
`ifndef THREE_STACKS_SHARED_MEMORY_MACROS_SVH
`define THREE_STACKS_SHARED_MEMORY_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TSSM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TSSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define TSSM_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define TSSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[rtl/core/tssm_pkg.sv]
// ----------------------------------------------------------------------------
// tssm_pkg
// types and constants shared by the shared-memory stack block
// ----------------------------------------------------------------------------
`default_nettype none

package tssm_pkg;

   localparam int NUM_STACKS = 3;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic               operation;
      logic [1:0]         stack_select;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pop_value;
      logic [1:0]         status;
      logic [2:0]         empty_mask;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic execute;
      logic load;
   } cmd_type;

endpackage

`default_nettype wire

[rtl/core/three_stacks_shared_memory.sv]
// ----------------------------------------------------------------------------
// three_stacks_shared_memory
// three lifo stacks in one shared memory, push and pop by request
// ----------------------------------------------------------------------------
// Three stacks of STACK_DEPTH 32-bit words each live in fixed segments of one
// single-port memory. Every request pushes a word onto, or pops the top word
// from, the selected stack and yields exactly one response with the popped
// word (zero unless a pop succeeded), a status (done, push refused because
// the stack is full, pop refused because the stack is empty) and the empty
// flags of all three stacks after the request. Select code three names no
// stack and is always refused. One request is handled at a time in three
// steps, set by the registered memory read: the request is captured at its
// accepting edge, the memory access happens in the execute step that follows
// and the response register loads in the load step after that; once it has
// loaded, the response is offered and the next request can be taken. A
// response waiting for rsp_ready holds the block in its load step. Fill
// counts reset to zero; memory words are never read before they are written
// and need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "three_stacks_shared_memory_macros.svh"

module three_stacks_shared_memory
   import tssm_pkg::*;
#(
   parameter int STACK_DEPTH = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   // command bundle from the sequencer into the datapath
   cmd_type cmd;

   // sequencer: request acceptance, memory step, response load
   tssm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // datapath: fill counts, shared memory, response register
   tssm_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

   // only one request in flight
   `TSSM_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "request accepted while busy")

   // refused requests never return data
   `TSSM_ASSERT_SAME(a_refused_zero, clock, reset, rsp_valid && (rsp_payload.status != ST_DONE), rsp_payload.pop_value == 32'sd0, "refused request returned data")

   // a new response only appears while a request is in flight
   `TSSM_ASSERT_SAME(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(!req_ready), "response without a request")

endmodule

`default_nettype wire

[rtl/core/tssm_datapath.sv]
// ----------------------------------------------------------------------------
// tssm_datapath
// request register, fill counts, shared stack memory and result register
// ----------------------------------------------------------------------------
`default_nettype none

module tssm_datapath
   import tssm_pkg::*;
#(
   parameter int STACK_DEPTH = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd,
   input  wire req_type req_payload,
   output rsp_type      rsp_payload
);

   localparam int MEM_WORDS = NUM_STACKS * STACK_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_WORDS);
   localparam int CNT_W     = $clog2(STACK_DEPTH + 1);

   req_type            req_ff;
   logic [CNT_W-1:0]   cnt_ff [NUM_STACKS];
   logic [CNT_W-1:0]   cnt_in [NUM_STACKS];
   logic signed [31:0] mem [MEM_WORDS];
   logic signed [31:0] rd_ff;
   logic               pop_ok_ff;
   status_type         status_ff;
   rsp_type            rsp_ff;

   logic [CNT_W-1:0]   cnt_cur;
   logic               push_ok;
   logic               pop_ok;
   logic [ADDR_W-1:0]  base;
   logic [ADDR_W-1:0]  addr;
   status_type         status_in;
   logic [2:0]         empty_mask;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
   end

   // count of the addressed stack, zero for the unused select code
   always_comb begin
      cnt_cur = '0;
      for (int k = 0; k < NUM_STACKS; k++) begin
         if (req_ff.stack_select == 2'(k)) begin
            cnt_cur = cnt_ff[k];
         end
      end
   end

   always_comb begin
      push_ok = (req_ff.stack_select < 2'(NUM_STACKS)) && (req_ff.operation == OP_PUSH)
                && (cnt_cur != CNT_W'(STACK_DEPTH));
      pop_ok  = (req_ff.stack_select < 2'(NUM_STACKS)) && (req_ff.operation == OP_POP)
                && (cnt_cur != '0);
      unique case (req_ff.stack_select)
         2'd1:    base = ADDR_W'(STACK_DEPTH);
         2'd2:    base = ADDR_W'(2 * STACK_DEPTH);
         default: base = '0;
      endcase
      if (req_ff.operation == OP_PUSH) begin
         addr = base + ADDR_W'(cnt_cur);
      end else begin
         addr = base + ADDR_W'(cnt_cur) - ADDR_W'(1);
      end
      priority if (push_ok || pop_ok) begin
         status_in = ST_DONE;
      end else if (req_ff.operation == OP_PUSH) begin
         status_in = ST_FULL;
      end else begin
         status_in = ST_EMPTY;
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_STACKS; k++) begin
         cnt_in[k] = cnt_ff[k];
         if (cmd.execute && req_ff.stack_select == 2'(k)) begin
            if (push_ok) begin
               cnt_in[k] = cnt_ff[k] + CNT_W'(1);
            end else if (pop_ok) begin
               cnt_in[k] = cnt_ff[k] - CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_STACKS; k++) begin
            cnt_ff[k] <= '0;
         end
      end else begin
         for (int k = 0; k < NUM_STACKS; k++) begin
            cnt_ff[k] <= cnt_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && push_ok) begin
         mem[addr] <= req_ff.push_value;
      end
      if (cmd.execute && pop_ok) begin
         rd_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         pop_ok_ff <= pop_ok;
         status_ff <= status_in;
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_STACKS; k++) begin
         empty_mask[k] = (cnt_ff[k] == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_ff.pop_value  <= pop_ok_ff ? rd_ff : 32'sd0;
         rsp_ff.status     <= status_ff;
         rsp_ff.empty_mask <= empty_mask;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

[rtl/core/tssm_ctrl.sv]
// ----------------------------------------------------------------------------
// tssm_ctrl
// sequencer for one request at a time and the result valid flag
// ----------------------------------------------------------------------------
`default_nettype none

module tssm_ctrl
   import tssm_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output cmd_type   cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_LOAD
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign cmd.capture = req_valid && (state_ff == S_IDLE);
   assign cmd.execute = (state_ff == S_EXEC);
   assign cmd.load    = (state_ff == S_LOAD) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire
